FILE: hdl/psa_pkg.sv
// Shared constants, types and helpers for the power spectrum accumulator.
// No dependencies; used by every module of the block but psa_ram.
package psa_pkg;

  localparam int unsigned FftSizeDef   = 1024;
  localparam int unsigned AccWidthDef  = 48;
  localparam int unsigned SampleWidth  = 16;
  localparam int unsigned PowerWidth   = 48;
  localparam int unsigned BinIndexW    = 10;
  localparam int unsigned ApbAddrW     = 3;
  localparam int unsigned ApbDataW     = 32;
  localparam int unsigned ScaleWidth   = 32;
  localparam int unsigned SquareWidth  = 2 * SampleWidth;

  // register map, word index
  localparam logic [ApbAddrW-3:0] RegPowerScale = '0;

  localparam logic [ScaleWidth-1:0] PowerScaleReset = '1;
  localparam logic [PowerWidth-1:0] PowerMax        = '1;

  // input word kinds carried on tuser
  localparam logic OpAccumulate = 1'b0;
  localparam logic OpReadClear  = 1'b1;

  // magnitude of a two's complement sample; the most negative value fits unsigned
  function automatic logic [SampleWidth-1:0] sample_mag(input logic [SampleWidth-1:0] s);
    logic [SampleWidth-1:0] neg;
    neg = ~s + 1'b1;
    return s[SampleWidth-1] ? neg : s;
  endfunction

endpackage

FILE: hdl/power_spectrum_accumulator.sv
// Power spectrum accumulator with half-swapped bin order. Every input word
// is one of two kinds, chosen by tuser: an accumulate word adds
// (re^2 + im^2) >> log2(FftSize) into the bin store at the half-swapped slot
// of the next natural-order sample, saturating at full scale; a read word
// emits the next slot's total times power_scale (Q0.32, truncated) with its
// index and tlast on the final slot, and clears that slot. An accumulate runs
// StAccSq then StAccWr after acceptance, and a read StRdLo then StRdHi, waiting in
// StRdHi while the output stalls; the steps are set by the read-modify-write of the
// single bin store (one registered read, then write-back) and, on reads, by the
// two-step product. After reset the store is zeroed by a pass over every slot,
// during which no word is accepted; configuration writes are taken throughout.
// FftSize must be a power of two. Depends on psa_pkg, psa_ram, psa_cfg, psa_scale.
module power_spectrum_accumulator
  import psa_pkg::*;
#(
  parameter int unsigned FftSize  = FftSizeDef,
  parameter int unsigned AccWidth = AccWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  // input words
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [31:0]         s_axis_tdata_i,  // sample_real[15:0], sample_imag[31:16]
  input  logic                s_axis_tuser_i,  // operation
  // result words
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [63:0]         m_axis_tdata_o,  // bin_power[47:0], bin_index[57:48], zero
  output logic                m_axis_tlast_o   // last_bin
);

  localparam int unsigned AW = $clog2(FftSize);
  localparam logic [AW-1:0] HalfSize = AW'(FftSize / 2);
  localparam logic [AW-1:0] LastSlot = AW'(FftSize - 1);

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StAccSq = 3'd2;
  localparam logic [2:0] StAccWr = 3'd3;
  localparam logic [2:0] StRdLo  = 3'd4;
  localparam logic [2:0] StRdHi  = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [AW-1:0]          clr_q, clr_d;
  logic [AW-1:0]          wcnt_q, wcnt_d;
  logic [AW-1:0]          rcnt_q, rcnt_d;
  logic [AW-1:0]          slot_q, slot_d;
  logic [SampleWidth-1:0] mag_re_q, mag_im_q;
  logic [SquareWidth:0]   pwr_q;
  logic                   out_valid_q, out_valid_d;
  logic [PowerWidth-1:0]  out_power_q;
  logic [AW-1:0]          out_slot_q;
  logic                   load_out;

  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [AccWidth-1:0]    ram_wdata, ram_rdata;
  logic [AccWidth:0]      acc_sum;
  logic [ScaleWidth-1:0]  scale;
  logic [PowerWidth-1:0]  scaled;
  logic                   in_acc;
  logic [SquareWidth-1:0] sq_re, sq_im;

  psa_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .scale_o (scale)
  );

  psa_ram #(
    .Width (AccWidth),
    .Depth (FftSize)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  psa_scale #(
    .AccWidth (AccWidth)
  ) u_scale (
    .clk_i     (clk_i),
    .capture_i (state_q == StRdLo),
    .acc_i     (ram_rdata),
    .scale_i   (scale),
    .power_o   (scaled)
  );

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  assign sq_re   = SquareWidth'(mag_re_q) * SquareWidth'(mag_re_q);
  assign sq_im   = SquareWidth'(mag_im_q) * SquareWidth'(mag_im_q);
  assign acc_sum = {1'b0, ram_rdata} + (AccWidth + 1)'(pwr_q);

  assign load_out = (state_q == StRdHi) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    wcnt_d    = wcnt_q;
    rcnt_d    = rcnt_q;
    slot_d    = slot_q;
    ram_we    = 1'b0;
    ram_waddr = slot_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = slot_d;
    case (state_q)
      StClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LastSlot) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_acc) begin
          ram_re = 1'b1;
          if (s_axis_tuser_i == OpReadClear) begin
            slot_d  = rcnt_q;
            rcnt_d  = rcnt_q + 1'b1;
            state_d = StRdLo;
          end else begin
            slot_d  = wcnt_q + HalfSize;  // half swap
            wcnt_d  = wcnt_q + 1'b1;
            state_d = StAccSq;
          end
          ram_raddr = slot_d;
        end
      end
      StAccSq: state_d = StAccWr;
      StAccWr: begin
        ram_we    = 1'b1;
        ram_wdata = acc_sum[AccWidth] ? '1 : acc_sum[AccWidth-1:0];
        state_d   = StIdle;
      end
      StRdLo: begin
        ram_we  = 1'b1;  // clear on read
        state_d = StRdHi;
      end
      StRdHi: begin
        if (load_out) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      wcnt_q      <= '0;
      rcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      wcnt_q      <= wcnt_d;
      rcnt_q      <= rcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    if (in_acc) begin
      mag_re_q <= sample_mag(s_axis_tdata_i[SampleWidth-1:0]);
      mag_im_q <= sample_mag(s_axis_tdata_i[16+SampleWidth-1:16]);
    end
    if (state_q == StAccSq) begin
      pwr_q <= (SquareWidth + 1)'(({1'b0, sq_re} + {1'b0, sq_im}) >> AW);
    end
    if (load_out) begin
      out_power_q <= scaled;
      out_slot_q  <= slot_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, BinIndexW'(out_slot_q), out_power_q};
  assign m_axis_tlast_o  = (out_slot_q == LastSlot);

  // no word taken while the store is being zeroed
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClear) |-> !s_axis_tready_o)
    else $error("input accepted during clearing pass");

  // a result appears only out of the readout step
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> ($past(state_q) == StRdHi))
    else $error("result word without a read");

  // store is never written while idle
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !ram_we)
    else $error("store written while idle");

  // each accumulate advances the natural-order sample counter by one
  a_wcnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (s_axis_tuser_i == OpAccumulate)) |=> (wcnt_q == $past(wcnt_q) + 1'b1))
    else $error("write bin counter did not advance");

endmodule

FILE: hdl/psa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module psa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/psa_cfg.sv
// APB register block holding the readout scale.
// Depends on psa_pkg.
module psa_cfg
  import psa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ApbAddrW-1:0]   paddr,
  input  logic [ApbDataW-1:0]   pwdata,
  output logic [ApbDataW-1:0]   prdata,
  output logic                  pready,
  output logic [ScaleWidth-1:0] scale_o
);

  logic [ScaleWidth-1:0] scale_q, scale_d;
  logic                  hit;

  // byte offset bits are ignored
  assign hit = (paddr[ApbAddrW-1:2] == RegPowerScale);

  always_comb begin
    scale_d = scale_q;
    if (psel && penable && pwrite && hit) begin
      scale_d = pwdata[ScaleWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= PowerScaleReset;
    end else begin
      scale_q <= scale_d;
    end
  end

  assign pready  = 1'b1;
  assign prdata  = hit ? ApbDataW'(scale_q) : '0;
  assign scale_o = scale_q;

endmodule

FILE: hdl/psa_scale.sv
// Readout scaler: accumulator times Q0.32 scale, truncated, saturated to 48 bits.
// Two steps, a 32x32 low product then the upper accumulator bits times the scale; depends on psa_pkg.
module psa_scale
  import psa_pkg::*;
#(
  parameter int unsigned AccWidth = AccWidthDef
) (
  input  logic                  clk_i,
  input  logic                  capture_i,
  input  logic [AccWidth-1:0]   acc_i,
  input  logic [ScaleWidth-1:0] scale_i,
  output logic [PowerWidth-1:0] power_o
);

  localparam int unsigned HiW  = (AccWidth > 32) ? AccWidth - 32 : 1;
  localparam int unsigned SumW = HiW + 32;

  logic [HiW-1:0]  hi_w;
  logic [HiW-1:0]  hi_q;
  logic [63:0]     lo_prod_q;
  logic [SumW-1:0] hi_prod;
  logic [SumW-1:0] total;

  if (AccWidth > 32) begin : g_hi
    assign hi_w = acc_i[AccWidth-1:32];
  end else begin : g_nohi
    assign hi_w = '0;
  end

  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      lo_prod_q <= 64'(acc_i[31:0]) * 64'(scale_i);
      hi_q      <= hi_w;
    end
  end

  assign hi_prod = SumW'(hi_q) * SumW'(scale_i);
  assign total   = hi_prod + SumW'(lo_prod_q[63:32]);
  assign power_o = (64'(total) > 64'(PowerMax)) ? PowerMax : PowerWidth'(total);

endmodule

FILE: dv/tb_power_spectrum_accumulator.sv
// Self-checking testbench for power_spectrum_accumulator: streams accumulate and
// read-clear words, predicts every bin readout and compares it field by field.
// Depends on psa_pkg and the power_spectrum_accumulator RTL.
module tb_power_spectrum_accumulator;
  import psa_pkg::*;

  localparam int unsigned Bins       = FftSizeDef;
  localparam int unsigned BinShift   = $clog2(Bins);
  localparam int unsigned RandWords  = 1100;
  localparam int unsigned SegWords   = 250;
  localparam int unsigned DrainWait  = 8;
  localparam int unsigned CycleLimit = 400_000;

  typedef struct packed {
    logic [PowerWidth-1:0] power;
    logic [BinIndexW-1:0]  idx;
    logic                  last;
  } bin_result_t;

  typedef struct {
    logic        op;
    logic [15:0] re;
    logic [15:0] im;
    bit          typed;
    bin_result_t want;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni          = 1'b0;
  logic                psel            = 1'b0;
  logic                penable         = 1'b0;
  logic                pwrite          = 1'b0;
  logic [ApbAddrW-1:0] paddr           = '0;
  logic [ApbDataW-1:0] pwdata          = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [31:0]         s_axis_tdata_i  = '0;  // sample_real[15:0], sample_imag[31:16]
  logic                s_axis_tuser_i  = 1'b0;  // operation
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [63:0]         m_axis_tdata_o;  // bin_power[47:0], bin_index[57:48], zero
  logic                m_axis_tlast_o;  // last_bin

  power_spectrum_accumulator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // predicted spectrum state
  logic [AccWidthDef-1:0] bin_totals [Bins];
  logic [BinIndexW-1:0]   sample_count;
  logic [BinIndexW-1:0]   readout_slot;
  logic [ScaleWidth-1:0]  scale_now;

  bin_result_t pending_bins [$];
  int          mismatches;
  int          src_idle_pct;
  int          dst_idle_pct;
  int unsigned cycles;

  stim_row_t directed_rows [15] = '{
    '{OpReadClear,  16'h0000, 16'h0000, 1'b1, {48'd0, 10'd0, 1'b0}},
    '{OpReadClear,  16'h0000, 16'h0000, 1'b1, {48'd0, 10'd1, 1'b0}},
    '{OpAccumulate, 16'h8000, 16'h8000, 1'b0, '0},
    '{OpAccumulate, 16'h7FFF, 16'h7FFF, 1'b0, '0},
    '{OpAccumulate, 16'h7FFF, 16'h8000, 1'b0, '0},
    '{OpAccumulate, 16'h8000, 16'h7FFF, 1'b0, '0},
    '{OpAccumulate, 16'h0000, 16'h0000, 1'b0, '0},
    '{OpAccumulate, 16'hFFFF, 16'hFFFF, 1'b0, '0},
    '{OpAccumulate, 16'h0001, 16'hFFFF, 1'b0, '0},
    '{OpAccumulate, 16'h5555, 16'hAAAA, 1'b0, '0},
    '{OpAccumulate, 16'hAAAA, 16'h5555, 1'b0, '0},
    '{OpReadClear,  16'hFFFF, 16'hFFFF, 1'b1, {48'd0, 10'd2, 1'b0}},
    '{OpReadClear,  16'h0000, 16'h0000, 1'b1, {48'd0, 10'd3, 1'b0}},
    '{OpAccumulate, 16'h1234, 16'hEDCB, 1'b0, '0},
    '{OpReadClear,  16'h0000, 16'h0000, 1'b1, {48'd0, 10'd4, 1'b0}}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] magnitude(input logic [15:0] s);
    int v;
    v = int'(signed'(s));
    return (v < 0) ? -v : v;
  endfunction

  // fftshift placement: sample k lands in slot k + Bins/2 (mod Bins)
  function automatic void add_sample_power(input logic [15:0] re, input logic [15:0] im);
    logic [63:0]          pwr;
    logic [63:0]          sum;
    logic [BinIndexW-1:0] slot;
    pwr  = (64'(magnitude(re)) * magnitude(re) + 64'(magnitude(im)) * magnitude(im))
           >> BinShift;
    slot = sample_count + BinIndexW'(Bins / 2);
    sum  = 64'(bin_totals[slot]) + pwr;
    bin_totals[slot] = (sum >> AccWidthDef != 0) ? '1 : sum[AccWidthDef-1:0];
    sample_count = sample_count + 1'b1;
  endfunction

  function automatic bin_result_t read_clear_bin();
    logic [AccWidthDef+ScaleWidth-1:0] prod;
    bin_result_t r;
    prod    = (AccWidthDef + ScaleWidth)'(bin_totals[readout_slot]) * scale_now;
    r.power = (prod >> (ScaleWidth + PowerWidth) != 0) ? PowerMax :
              prod[ScaleWidth +: PowerWidth];
    r.idx   = readout_slot;
    r.last  = (readout_slot == BinIndexW'(Bins - 1));
    bin_totals[readout_slot] = '0;
    readout_slot = readout_slot + 1'b1;
    return r;
  endfunction

  function automatic logic [15:0] draw_sample();
    case ($urandom_range(0, 11))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic op, input logic [15:0] re, input logic [15:0] im,
                           input bit typed, input bin_result_t want);
    int gap;
    bin_result_t got;
    gap = 0;
    while ($urandom_range(0, 99) < src_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {im, re};
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (op == OpAccumulate) begin
      add_sample_power(re, im);
    end else begin
      got = read_clear_bin();
      pending_bins.push_back(typed ? want : got);
    end
  endtask

  // accumulate words give no result, so allow the pipeline to empty as well
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_scale(input logic [ScaleWidth-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegPowerScale, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    scale_now = v;
    // read back straight after
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== v) begin
      $error("power_scale: expected %h, got %h", v, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic void pick_idling(input int unsigned n);
    if (n < 370) begin
      src_idle_pct = 34;
      dst_idle_pct = 71;
    end else if (n < 740) begin
      src_idle_pct = 71;
      dst_idle_pct = 34;
    end else begin
      src_idle_pct = 0;
      dst_idle_pct = 0;
    end
  endfunction

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= dst_idle_pct);
  end

  always @(posedge clk_i) begin
    bin_result_t e;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_bins.size() == 0) begin
        $error("result word with nothing expected: tdata %h", m_axis_tdata_o);
        mismatches++;
      end else begin
        e = pending_bins.pop_front();
        if (m_axis_tdata_o[PowerWidth-1:0] !== e.power) begin
          $error("bin_power: expected %0d, got %0d", e.power, m_axis_tdata_o[PowerWidth-1:0]);
          mismatches++;
        end
        if (m_axis_tdata_o[PowerWidth +: BinIndexW] !== e.idx) begin
          $error("bin_index: expected %0d, got %0d", e.idx,
                 m_axis_tdata_o[PowerWidth +: BinIndexW]);
          mismatches++;
        end
        if (m_axis_tlast_o !== e.last) begin
          $error("last_bin: expected %0b, got %0b", e.last, m_axis_tlast_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned rnd_words;
    int unsigned seg;
    int unsigned seg_end;
    int unsigned burst;
    logic        op;
    bit          mixed;

    for (int i = 0; i < Bins; i++) bin_totals[i] = '0;
    sample_count    = '0;
    readout_slot    = '0;
    scale_now       = PowerScaleReset;
    mismatches      = 0;
    cycles          = 0;
    rnd_words       = 0;
    seg             = 0;
    pick_idling(0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed words run with the reset scale
    foreach (directed_rows[i])
      send_word(directed_rows[i].op, directed_rows[i].re, directed_rows[i].im,
                directed_rows[i].typed, directed_rows[i].want);

    // bursts of samples and readouts, a new scale per segment
    while (rnd_words < RandWords) begin
      drain();
      case (seg)
        0:       write_scale(32'hFFFF_FFFF);
        1:       write_scale(32'h0000_0000);
        2:       write_scale(32'h0000_0001);
        3:       write_scale(32'h8000_0000);
        default: write_scale($urandom);
      endcase
      seg_end = rnd_words + ((seg == 1 || seg == 2) ? 60 : SegWords);
      while (rnd_words < seg_end) begin
        op    = $urandom_range(0, 1) ? OpReadClear : OpAccumulate;
        mixed = ($urandom_range(0, 7) == 0);
        burst = $urandom_range(1, 64);
        repeat (burst) begin
          pick_idling(rnd_words);
          if (mixed) op = $urandom_range(0, 1) ? OpReadClear : OpAccumulate;
          send_word(op, draw_sample(), draw_sample(), 1'b0, '0);
          rnd_words++;
        end
      end
      seg++;
    end

    drain();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
